// File: src/fwda_pkg.sv
`default_nettype none

package fwda_pkg;

    // Canonical quiet NaN used for every NaN result
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_ACT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADD_BIAS  = 2'd1;

    // Word held in the queue between front and back
    typedef struct packed {
        logic [31:0] weight;
        logic [31:0] activation;
        logic [31:0] bias;
        logic        last;
    } word_t;

    // Unpacked binary32 operand, significand normalised to bit 23
    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               zero;
        logic               sign;
        logic signed [9:0]  exp;
        logic [23:0]        sig;
    } unpacked_t;

    // Leading zero count, 24 bits
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    // Leading zero count, 27 bits
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) n = 5'(26 - i);
        end
        return n;
    endfunction

    // Exact widening of binary16 to binary32
    function automatic logic [31:0] half_widen(input logic [15:0] h);
        logic        sign;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  pos;
        logic [10:0] sh;
        logic [31:0] r;
        sign = h[15];
        ex   = h[14:10];
        man  = h[9:0];
        pos  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) pos = 4'(i);
        end
        sh = {1'b0, man} << (4'd10 - pos);
        if (ex == 5'd0) begin
            if (man == 10'd0) r = {sign, 31'd0};
            else r = {sign, 8'(8'd103 + {4'd0, pos}), sh[9:0], 13'd0};
        end
        else if (ex == 5'h1F) begin
            r = {sign, 8'hFF, man, 13'd0};
        end
        else begin
            r = {sign, 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return r;
    endfunction

    // binary32 to binary16, round to nearest even
    function automatic logic [15:0] half_narrow(input logic [31:0] f);
        logic               sign;
        logic [7:0]         ex;
        logic [22:0]        man;
        logic signed [9:0]  e;
        logic [23:0]        m;
        logic [4:0]         shift;
        logic [23:0]        hs;
        logic [23:0]        rem;
        logic [23:0]        half;
        logic [15:0]        h;
        sign = f[31];
        ex   = f[30:23];
        man  = f[22:0];
        e    = $signed({2'b00, ex}) - 10'sd112;
        m    = {1'b1, man};
        shift = 5'(10'sd14 - e);
        hs   = m >> shift;
        rem  = m & ~(24'hFF_FFFF << shift);
        half = 24'd1 << (shift - 5'd1);
        if (ex == 8'hFF) begin
            if (man != 23'd0) h = {sign, 5'h1F, 1'b1, man[21:13]};
            else h = {sign, 15'h7C00};
        end
        else if (e >= 10'sd31) begin
            h = {sign, 15'h7C00};
        end
        else if (e <= 10'sd0) begin
            if (e < -10'sd10) begin
                h = {sign, 15'd0};
            end
            else begin
                if (rem > half || (rem == half && hs[0])) hs = hs + 24'd1;
                h = {sign, hs[14:0]};
            end
        end
        else begin
            h = {sign, e[4:0], man[22:13]};
            if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && h[0]))
                h = h + 16'd1;
        end
        return h;
    endfunction

    // Classify and normalise a binary32 operand
    function automatic unpacked_t unpack32(input logic [31:0] f);
        unpacked_t  u;
        logic [23:0] sig;
        logic [4:0]  lz;
        sig    = {|f[30:23], f[22:0]};
        lz     = lzc24(sig);
        u.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
        u.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
        u.zero = (f[30:0] == 31'd0);
        u.sign = f[31];
        if (f[30:23] == 8'd0) begin
            u.sig = sig << lz;
            u.exp = -10'sd126 - $signed({5'd0, lz});
        end
        else begin
            u.sig = sig;
            u.exp = $signed({2'b00, f[30:23]}) - 10'sd127;
        end
        return u;
    endfunction

    // Round and pack: m[26] is the leading one, m[2:0] guard/round/sticky,
    // e is the biased exponent of m[26]
    function automatic logic [31:0] round_pack(input logic s,
                                               input logic signed [9:0] e,
                                               input logic [26:0] m);
        logic [9:0]  sh;
        logic [26:0] mm;
        logic [7:0]  ef;
        logic        inc;
        logic [30:0] pk;
        logic [31:0] r;
        sh = 10'(10'sd1 - e);
        mm = m;
        ef = e[7:0];
        if (e <= 10'sd0) begin
            ef = 8'd0;
            if (sh > 10'd26) begin
                mm = {26'd0, |m};
            end
            else begin
                mm = m >> sh[4:0];
                mm[0] = mm[0] | (|(m & ~({27{1'b1}} << sh[4:0])));
            end
        end
        inc = mm[2] & (mm[1] | mm[0] | mm[3]);
        pk  = {ef, mm[25:3]} + {30'd0, inc};
        if (m == 27'd0) r = {s, 31'd0};
        else if (e >= 10'sd255) r = {s, 8'hFF, 23'd0};
        else r = {s, pk};
        return r;
    endfunction

    // binary32 add, round to nearest even, subnormals kept
    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic               nan_a;
        logic               nan_b;
        logic               inf_a;
        logic               inf_b;
        logic [31:0]        big;
        logic [31:0]        sml;
        logic [7:0]         eb;
        logic [7:0]         es;
        logic [7:0]         d;
        logic               sub;
        logic [26:0]        af;
        logic [26:0]        bf;
        logic [26:0]        bs;
        logic [27:0]        s;
        logic [4:0]         lz;
        logic [26:0]        m;
        logic signed [9:0]  e;
        logic [31:0]        r;
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (b[30:0] > a[30:0]) begin
            big = b;
            sml = a;
        end
        else begin
            big = a;
            sml = b;
        end
        eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d   = eb - es;
        sub = big[31] ^ sml[31];
        af  = {|big[30:23], big[22:0], 3'd0};
        bf  = {|sml[30:23], sml[22:0], 3'd0};
        if (d > 8'd26) begin
            bs = {26'd0, |bf};
        end
        else begin
            bs = bf >> d[4:0];
            bs[0] = bs[0] | (|(bf & ~({27{1'b1}} << d[4:0])));
        end
        s  = sub ? ({1'b0, af} - {1'b0, bs}) : ({1'b0, af} + {1'b0, bs});
        lz = lzc27(s[26:0]);
        if (s[27]) begin
            m = {s[27:2], s[1] | s[0]};
            e = $signed({2'b00, eb}) + 10'sd1;
        end
        else begin
            m = s[26:0] << lz;
            e = $signed({2'b00, eb}) - $signed({5'd0, lz});
        end
        if (nan_a || nan_b) r = CANON_NAN;
        else if (inf_a && inf_b) r = (a[31] != b[31]) ? CANON_NAN : a;
        else if (inf_a) r = a;
        else if (inf_b) r = b;
        else if (s == 28'd0) r = sub ? POS_ZERO : {big[31], 31'd0};
        else r = round_pack(big[31], e, m);
        return r;
    endfunction

    // Any NaN leaves the block as the canonical NaN
    function automatic logic [31:0] canon(input logic [31:0] f);
        logic [31:0] r;
        r = f;
        if (f[30:23] == 8'hFF && f[22:0] != 23'd0) r = CANON_NAN;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/fwda_front.sv
`default_nettype none

module fwda_front (
    input  wire logic              round_act,
    input  wire logic [15:0]       weight_half,
    input  wire logic [31:0]       activation_bits,
    input  wire logic [31:0]       bias_bits,
    input  wire logic              last_of_dot,
    output fwda_pkg::word_t        word
);

    logic [31:0] act_rounded;

    // Activation optionally squeezed through binary16
    assign act_rounded = fwda_pkg::half_widen(fwda_pkg::half_narrow(activation_bits));

    // Weight widened exactly; word ready for the queue
    always_comb
    begin
        word.weight     = fwda_pkg::half_widen(weight_half);
        word.activation = round_act ? act_rounded : activation_bits;
        word.bias       = bias_bits;
        word.last       = last_of_dot;
    end

endmodule

`default_nettype wire

// File: src/fwda_queue.sv
`default_nettype none

module fwda_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  fwda_pkg::word_t        push_word,
    output logic                   full,
    input  wire logic              pop,
    output fwda_pkg::word_t        pop_word,
    output logic                   not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fwda_pkg::word_t   store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_word  = store_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop) rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push) store_reg[wr_ptr_reg] <= push_word;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count past depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && count_reg == '0) |-> 1'b0)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: src/fwda_back.sv
`default_nettype none

module fwda_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              add_bias,
    input  wire logic              word_valid,
    input  fwda_pkg::word_t        word,
    output logic                   pop,
    output logic [31:0]            sum_bits,
    output logic                   sum_valid,
    input  wire logic              sum_stall
);

    typedef struct packed {
        fwda_pkg::unpacked_t uw;
        fwda_pkg::unpacked_t ua;
        logic [31:0]         bias;
        logic                last;
    } s1_t;

    typedef struct packed {
        logic [47:0]         prod;
        logic signed [9:0]   esum;
        logic                sign;
        logic                spec;
        logic [31:0]         spec_bits;
        logic [31:0]         bias;
        logic                last;
    } s2_t;

    typedef struct packed {
        logic [31:0]         prod;
        logic [31:0]         bias;
        logic                last;
    } s3_t;

    typedef struct packed {
        logic [31:0]         sum;
        logic [31:0]         bias;
    } s4_t;

    logic        adv;
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        s3_valid_reg;
    logic        s4_valid_reg;
    logic        out_valid_reg;
    s1_t         s1_reg;
    s1_t         s1_next;
    s2_t         s2_reg;
    s2_t         s2_next;
    s3_t         s3_reg;
    s3_t         s3_next;
    s4_t         s4_reg;
    s4_t         s4_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] acc_sum;
    logic [31:0] sum_bits_reg;
    logic [31:0] sum_bits_next;

    // Whole back pipeline moves unless the output word is held
    assign adv       = !out_valid_reg || !sum_stall;
    assign pop       = adv && word_valid;
    assign sum_valid = out_valid_reg;
    assign sum_bits  = sum_bits_reg;

    // Stage 1: unpack operands
    always_comb
    begin
        s1_next.uw   = fwda_pkg::unpack32(word.weight);
        s1_next.ua   = fwda_pkg::unpack32(word.activation);
        s1_next.bias = word.bias;
        s1_next.last = word.last;
    end

    // Stage 2: significand multiply, special operands
    always_comb
    begin
        s2_next.prod = 48'(s1_reg.uw.sig) * 48'(s1_reg.ua.sig);
        s2_next.esum = s1_reg.uw.exp + s1_reg.ua.exp;
        s2_next.sign = s1_reg.uw.sign ^ s1_reg.ua.sign;
        s2_next.spec = 1'b1;
        s2_next.bias = s1_reg.bias;
        s2_next.last = s1_reg.last;
        if (s1_reg.uw.nan || s1_reg.ua.nan
            || (s1_reg.uw.inf && s1_reg.ua.zero) || (s1_reg.ua.inf && s1_reg.uw.zero))
            s2_next.spec_bits = fwda_pkg::CANON_NAN;
        else if (s1_reg.uw.inf || s1_reg.ua.inf)
            s2_next.spec_bits = {s2_next.sign, 8'hFF, 23'd0};
        else if (s1_reg.uw.zero || s1_reg.ua.zero)
            s2_next.spec_bits = {s2_next.sign, 31'd0};
        else
        begin
            s2_next.spec      = 1'b0;
            s2_next.spec_bits = fwda_pkg::POS_ZERO;
        end
    end

    // Stage 3: round the product to binary32
    always_comb
    begin
        s3_next.bias = s2_reg.bias;
        s3_next.last = s2_reg.last;
        if (s2_reg.spec)
            s3_next.prod = s2_reg.spec_bits;
        else if (s2_reg.prod[47])
            s3_next.prod = fwda_pkg::round_pack(s2_reg.sign, s2_reg.esum + 10'sd128,
                {s2_reg.prod[47:22], |s2_reg.prod[21:0]});
        else
            s3_next.prod = fwda_pkg::round_pack(s2_reg.sign, s2_reg.esum + 10'sd127,
                {s2_reg.prod[46:21], |s2_reg.prod[20:0]});
    end

    // Stage 4: accumulate, clear on the last element
    assign acc_sum = fwda_pkg::fadd(acc_reg, s3_reg.prod);

    always_comb
    begin
        acc_next     = acc_reg;
        s4_next.sum  = acc_sum;
        s4_next.bias = s3_reg.bias;
        if (s3_valid_reg) acc_next = s3_reg.last ? fwda_pkg::POS_ZERO : acc_sum;
    end

    // Stage 5: optional bias, NaN canonicalised
    assign sum_bits_next = fwda_pkg::canon(add_bias ? fwda_pkg::fadd(s4_reg.sum, s4_reg.bias)
                                                    : s4_reg.sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= fwda_pkg::POS_ZERO;
        end
        else if (adv)
        begin
            s1_valid_reg  <= word_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg && s3_reg.last;
            out_valid_reg <= s4_valid_reg;
            acc_reg       <= acc_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            s4_reg       <= s4_next;
            sum_bits_reg <= sum_bits_next;
        end
    end

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s3_valid_reg && s3_reg.last) |=> (acc_reg == fwda_pkg::POS_ZERO))
        else $error("accumulator not cleared after last element");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s4_valid_reg))
        else $error("result word without a finished dot");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(acc_reg))
        else $error("accumulator moved while output held");

endmodule

`default_nettype wire

// File: src/fp16_weight_dot_accumulate.sv
`default_nettype none

// Streaming dot product: binary16 weights times binary32 activations, summed
// in binary32 with separate RNE roundings for multiply and add. One element
// per cycle is taken, with one result word per dot on the last element. The
// input side only stalls when the QUEUE_DEPTH word queue is full; behind it a
// five-stage pipeline (unpack, multiply, round, accumulate, bias) runs, and each
// result is held in the bias stage register until it is taken. The
// combinational accumulator adder is the loop that sets the one-element-per-cycle rate.
// Configuration: index 0 rounds activations to binary16 first, index 1 adds
// bias_bits to each finished sum; write only while the block is idle.
module fp16_weight_dot_accumulate #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire logic [15:0]                      weight_half,
    input  wire logic [31:0]                      activation_bits,
    input  wire logic [31:0]                      bias_bits,
    input  wire logic                             last_of_dot,
    output logic                                  sum_valid,
    input  wire logic                             sum_stall,
    output logic [31:0]                           sum_bits,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fwda_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic                             cfg_data
);

    logic            round_act_reg;
    logic            add_bias_reg;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;
    logic            q_push;
    fwda_pkg::word_t front_word;
    fwda_pkg::word_t q_word;

    assign cfg_ready  = 1'b1;
    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_act_reg <= 1'b0;
            add_bias_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fwda_pkg::CFG_ROUND_ACT: round_act_reg <= cfg_data;
                fwda_pkg::CFG_ADD_BIAS:  add_bias_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    fwda_front u_front (
        .round_act       (round_act_reg),
        .weight_half     (weight_half),
        .activation_bits (activation_bits),
        .bias_bits       (bias_bits),
        .last_of_dot     (last_of_dot),
        .word            (front_word)
    );

    fwda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (front_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (q_word),
        .not_empty (q_not_empty)
    );

    fwda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .add_bias   (add_bias_reg),
        .word_valid (q_not_empty),
        .word       (q_word),
        .pop        (q_pop),
        .sum_bits   (sum_bits),
        .sum_valid  (sum_valid),
        .sum_stall  (sum_stall)
    );

endmodule

`default_nettype wire
